@@ sv/lkdfb_pkg.sv @@
package lkdfb_pkg;

   localparam int MAX_DIGITS      = 8;
   localparam int DEF_NUM_DIGITS  = 8;
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam int FUNC_W   = 3;
   localparam int ADDR_W   = 4;
   localparam int NUMBER_W = 27;
   localparam int BYTE_W   = 8;
   localparam int SCAN_W   = 32;
   localparam int KEY_W    = 4;
   localparam int BRIGHT_W = 3;
   localparam int STEP_W   = 5;

   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;
   localparam logic [KEY_W-1:0]    KEY_NONE     = 4'd8;

   localparam logic [BYTE_W-1:0] CMD_DATA_AUTO  = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_DATA_FIXED = 8'h44;
   localparam logic [BYTE_W-1:0] CMD_READ_KEYS  = 8'h42;
   localparam logic [BYTE_W-1:0] CMD_ADDR       = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON = 8'h88;
   localparam logic [BYTE_W-1:0] FILL_BYTE      = 8'hFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SHOW  = 3'd0,
      FUNC_LED   = 3'd1,
      FUNC_INIT  = 3'd2,
      FUNC_KEY   = 3'd3,
      FUNC_WRITE = 3'd4,
      FUNC_FIXED = 3'd5
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   data_byte;
      logic [KEY_W-1:0]    key_index;
      logic [STEP_W-1:0]   last_step;
   } job_type;

   function automatic logic [BYTE_W-1:0] seg_code(input logic [3:0] digit);
      logic [BYTE_W-1:0] code;
      unique case (digit)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7F;
         4'd9: code = 8'h6F;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic int pow10(input int n);
      int p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   function automatic logic [KEY_W-1:0] key_decode(input logic [SCAN_W-1:0] scan);
      logic [7:0]       merged;
      logic [KEY_W-1:0] idx;
      merged = scan[7:0] | {scan[14:8], 1'b0} | {scan[21:16], 2'b0} | {scan[28:24], 3'b0};
      idx = KEY_NONE;
      for (int i = 0; i < 8; i++) begin
         if (merged == (8'd1 << i)) begin
            idx = KEY_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ sv/lkdfb_front.sv @@
module lkdfb_front
   import lkdfb_pkg::*;
#(
   parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [ADDR_W-1:0]       req_address,
   input  logic [NUMBER_W-1:0]     req_number,
   input  logic [BYTE_W-1:0]       req_data_byte,
   input  logic [SCAN_W-1:0]       req_key_scan,
   output logic                    push,
   output job_type                 job,
   output logic [4*NUM_DIGITS-1:0] digits,
   input  logic                    full
);

   localparam int                  BCD_W   = 4 * NUM_DIGITS;
   localparam int                  ITER_W  = $clog2(NUMBER_W);
   localparam logic [NUMBER_W-1:0] MAX_NUM = NUMBER_W'(pow10(NUM_DIGITS) - 1);

   localparam logic [STEP_W-1:0] LAST_SHOW  = STEP_W'(2 * NUM_DIGITS);
   localparam logic [STEP_W-1:0] LAST_LED   = STEP_W'(3 * NUM_DIGITS - 1);
   localparam logic [STEP_W-1:0] LAST_INIT  = STEP_W'(18);
   localparam logic [STEP_W-1:0] LAST_KEY   = STEP_W'(1);
   localparam logic [STEP_W-1:0] LAST_WRITE = STEP_W'(2);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   fstate_type              state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [NUMBER_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic [BCD_W-1:0]        adj;
   logic                    accept;
   logic                    known_func;
   logic [STEP_W-1:0]       last_step;

   assign busy   = (state_ff != F_IDLE);
   assign accept = start && !busy;
   assign push   = (state_ff == F_PUSH) && !full;
   assign job    = job_ff;
   assign digits = bcd_ff;

   always_comb begin
      known_func = 1'b1;
      last_step  = LAST_WRITE;
      unique case (req_func)
         FUNC_SHOW:  last_step = LAST_SHOW;
         FUNC_LED:   last_step = LAST_LED;
         FUNC_INIT:  last_step = LAST_INIT;
         FUNC_KEY:   last_step = LAST_KEY;
         FUNC_WRITE: last_step = LAST_WRITE;
         FUNC_FIXED: last_step = LAST_WRITE;
         default:    known_func = 1'b0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept && known_func) begin
               job_in.func      = func_type'(req_func);
               job_in.address   = req_address;
               job_in.data_byte = req_data_byte;
               job_in.key_index = key_decode(req_key_scan);
               job_in.last_step = last_step;
               bin_in  = (req_number > MAX_NUM) ? MAX_NUM : req_number;
               bcd_in  = '0;
               iter_in = '0;
               state_in = (req_func == FUNC_SHOW) ? F_CONV : F_PUSH;
            end
         end
         F_CONV: begin
            bcd_in  = {adj[BCD_W-2:0], bin_ff[NUMBER_W-1]};
            bin_in  = bin_ff << 1;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(NUMBER_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      iter_ff <= iter_in;
   end

endmodule

@@ sv/lkdfb_queue.sv @@
module lkdfb_queue
   import lkdfb_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/lkdfb_back.sv @@
module lkdfb_back
   import lkdfb_pkg::*;
#(
   parameter int NUM_DIGITS = DEF_NUM_DIGITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [BRIGHT_W-1:0]     brightness,
   input  logic                    empty,
   input  job_type                 pop_job,
   input  logic [4*NUM_DIGITS-1:0] pop_digits,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [BYTE_W-1:0]       rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_strobe_end,
   output logic [KEY_W-1:0]        rsp_key_index,
   output logic                    rsp_last
);

   localparam int BCD_W = 4 * NUM_DIGITS;
   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   localparam logic [1:0] SUB_CMD  = 2'd0;
   localparam logic [1:0] SUB_ADDR = 2'd1;
   localparam logic [1:0] SUB_DATA = 2'd2;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } bstate_type;

   bstate_type          state_ff, state_in;
   job_type             job_ff, job_in;
   logic [BCD_W-1:0]    digits_ff, digits_in;
   logic [BYTE_W-1:0]   mask_ff, mask_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          sub_ff, sub_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   logic                valid_ff;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                byte_valid_ff, byte_valid_in;
   logic                strobe_ff, strobe_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic                last_ff, last_in;

   logic                emit;
   logic                final_step;

   assign pop        = (state_ff == B_IDLE) && !empty;
   assign emit       = (state_ff == B_RUN);
   assign final_step = (step_ff == job_ff.last_step);

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_strobe_end = strobe_ff;
   assign rsp_key_index  = key_ff;
   assign rsp_last       = last_ff;

   always_comb begin
      byte_in       = '0;
      byte_valid_in = 1'b1;
      strobe_in     = 1'b0;
      key_in        = KEY_NONE;
      last_in       = final_step;
      unique case (job_ff.func)
         FUNC_SHOW: begin
            if (step_ff == '0) begin
               byte_in = CMD_ADDR | {4'b0, job_ff.address};
            end else begin
               byte_in   = seg_code(digits_ff[BCD_W-1 -: 4]);
               strobe_in = final_step;
            end
         end
         FUNC_LED: begin
            priority if (sub_ff == SUB_CMD) begin
               byte_in   = CMD_DATA_AUTO;
               strobe_in = 1'b1;
            end else if (sub_ff == SUB_ADDR) begin
               byte_in = CMD_ADDR | BYTE_W'({idx_ff, 1'b1});
            end else begin
               byte_in   = {7'b0, mask_ff[0]};
               strobe_in = 1'b1;
            end
         end
         FUNC_INIT: begin
            priority if (step_ff == STEP_W'(0)) begin
               byte_in   = CMD_DISPLAY_ON | {5'b0, brightness};
               strobe_in = 1'b1;
            end else if (step_ff == STEP_W'(1)) begin
               byte_in   = CMD_DATA_AUTO;
               strobe_in = 1'b1;
            end else if (step_ff == STEP_W'(2)) begin
               byte_in = CMD_ADDR;
            end else begin
               byte_in   = FILL_BYTE;
               strobe_in = final_step;
            end
         end
         FUNC_KEY: begin
            if (step_ff == '0) begin
               byte_in = CMD_READ_KEYS;
            end else begin
               byte_valid_in = 1'b0;
               strobe_in     = 1'b1;
               key_in        = job_ff.key_index;
            end
         end
         FUNC_WRITE, FUNC_FIXED: begin
            priority if (step_ff == STEP_W'(0)) begin
               byte_in   = (job_ff.func == FUNC_WRITE) ? CMD_DATA_AUTO : CMD_DATA_FIXED;
               strobe_in = 1'b1;
            end else if (step_ff == STEP_W'(1)) begin
               byte_in = (job_ff.func == FUNC_WRITE)
                         ? (CMD_ADDR | {4'b0, job_ff.address})
                         : (CMD_ADDR | {4'b0, job_ff.address[2:0], 1'b0});
            end else begin
               byte_in   = job_ff.data_byte;
               strobe_in = 1'b1;
            end
         end
         default: byte_valid_in = 1'b1;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      digits_in = digits_ff;
      mask_in   = mask_ff;
      step_in   = step_ff;
      sub_in    = sub_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               job_in    = pop_job;
               digits_in = pop_digits;
               mask_in   = pop_job.data_byte;
               step_in   = '0;
               sub_in    = SUB_CMD;
               idx_in    = '0;
               state_in  = B_RUN;
            end
         end
         B_RUN: begin
            step_in = step_ff + 1'b1;
            if (job_ff.func == FUNC_LED) begin
               if (sub_ff == SUB_DATA) begin
                  sub_in  = SUB_CMD;
                  idx_in  = idx_ff + 1'b1;
                  mask_in = mask_ff >> 1;
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end
            // second copy of a digit done: move to the next digit
            if (job_ff.func == FUNC_SHOW && step_ff != '0 && !step_ff[0]) begin
               digits_in = digits_ff << 4;
            end
            if (final_step) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= emit;
      end
      job_ff    <= job_in;
      digits_ff <= digits_in;
      mask_ff   <= mask_in;
      step_ff   <= step_in;
      sub_ff    <= sub_in;
      idx_ff    <= idx_in;
      if (emit) begin
         byte_ff       <= byte_in;
         byte_valid_ff <= byte_valid_in;
         strobe_ff     <= strobe_in;
         key_ff        <= key_in;
         last_ff       <= last_in;
      end
   end

endmodule

@@ sv/led_key_display_frame_builder_core.sv @@
// Frame builder for an 8-digit LED/key driver chip.
// Request channel: a transaction is taken at a clock edge with start high and
// busy low; req_func selects show-number, LED mask, init, key decode, write
// byte or fixed-address write. Codes 6 and 7 are taken and give no results.
// Result channel: each result is shown for one cycle with rsp_valid high;
// rsp_strobe_end marks the strobe rising after that byte, rsp_last the final
// result of the request. The receiver cannot stall, so results never wait.
// Config: csr_write_enable/csr_write_data set the brightness used at init.
// Timing: the front holds a show-number request for its bit-per-cycle
// binary-to-decimal conversion, other requests only until they are pushed.
// Jobs then wait in a small queue; the back loads one job at a time and
// emits one result per cycle (up to 24). With the back free, a pushed job
// passes the queue entry, the back's job and result registers before it shows. busy stays high while the
// front works or waits for room in the queue.
// Reset: queue empty, both sequencers idle, brightness 7.
module led_key_display_frame_builder_core
   import lkdfb_pkg::*;
#(
   parameter int NUM_DIGITS  = DEF_NUM_DIGITS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [NUMBER_W-1:0] req_number,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [SCAN_W-1:0]   req_key_scan,
   output logic                rsp_valid,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_strobe_end,
   output logic [KEY_W-1:0]    rsp_key_index,
   output logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [BRIGHT_W-1:0] csr_write_data
);

   localparam int BCD_W   = 4 * NUM_DIGITS;
   localparam int QENTRY_W = $bits(job_type) + BCD_W;

   logic [BRIGHT_W-1:0] brightness_ff, brightness_in;

   logic                push;
   job_type             push_job;
   logic [BCD_W-1:0]    push_digits;
   logic                full;
   logic                pop;
   logic                empty;
   logic [QENTRY_W-1:0] pop_data;
   job_type             pop_job;
   logic [BCD_W-1:0]    pop_digits;

   assign brightness_in = csr_write_enable ? csr_write_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_RESET;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   assign pop_job    = job_type'(pop_data[QENTRY_W-1 -: $bits(job_type)]);
   assign pop_digits = pop_data[BCD_W-1:0];

   lkdfb_front #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_address   (req_address),
      .req_number    (req_number),
      .req_data_byte (req_data_byte),
      .req_key_scan  (req_key_scan),
      .push          (push),
      .job           (push_job),
      .digits        (push_digits),
      .full          (full)
   );

   lkdfb_queue #(
      .WIDTH (QENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_job, push_digits}),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   lkdfb_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .brightness     (brightness_ff),
      .empty          (empty),
      .pop_job        (pop_job),
      .pop_digits     (pop_digits),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_strobe_end (rsp_strobe_end),
      .rsp_key_index  (rsp_key_index),
      .rsp_last       (rsp_last)
   );

endmodule

@@ sv/lkdfb_checker.sv @@
module lkdfb_checker
   import lkdfb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [FUNC_W-1:0]   req_func,
   input logic                rsp_valid,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_byte_valid,
   input logic                rsp_strobe_end,
   input logic [KEY_W-1:0]    rsp_key_index,
   input logic                rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func <= FUNC_FIXED |=> busy)
      else $error("known request taken without busy rising");

   a_key_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_strobe_end)
      else $error("key result does not close the request");

   a_key_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> $past(rsp_valid) && $past(rsp_out_byte) == CMD_READ_KEYS)
      else $error("key result not preceded by key read command");

   a_no_key_on_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_key_index == KEY_NONE)
      else $error("key index set on a byte result");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind led_key_display_frame_builder_core lkdfb_checker u_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import lkdfb_pkg::*;

   localparam int NDIG         = DEF_NUM_DIGITS;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 85;
   localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
   localparam logic [BYTE_W-1:0] SEG_FONT [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                                  8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [ADDR_W-1:0]   address;
      logic [NUMBER_W-1:0] number;
      logic [BYTE_W-1:0]   data_byte;
      logic [SCAN_W-1:0]   key_scan;
   } request_type;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              strobe_end;
      logic [KEY_W-1:0]  key_index;
      logic              last;
   } frame_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [NUMBER_W-1:0] req_number = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [SCAN_W-1:0]   req_key_scan = '0;
   logic                rsp_valid;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_strobe_end;
   logic [KEY_W-1:0]    rsp_key_index;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [BRIGHT_W-1:0] csr_write_data = '0;

   request_type       req_pending[$];
   request_type       drv_req;
   frame_byte_type    frame_q[$];
   logic [BRIGHT_W-1:0] bright_model = BRIGHT_RESET;
   bit                gaps_on = 1'b1;
   int                mismatches = 0;
   int                bytes_checked = 0;
   int                func_seen[8] = '{default: 0};

   led_key_display_frame_builder_core uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void push_byte(logic [BYTE_W-1:0] b, logic v, logic s,
                                      logic [KEY_W-1:0] k);
      frame_byte_type fb;
      fb.out_byte   = b;
      fb.byte_valid = v;
      fb.strobe_end = s;
      fb.key_index  = k;
      fb.last       = 1'b0;
      frame_q.push_back(fb);
   endfunction

   function automatic logic [KEY_W-1:0] pressed_key(logic [SCAN_W-1:0] scan);
      logic [11:0] merged;
      logic [KEY_W-1:0] idx;
      merged = {4'd0, scan[7:0]} | ({4'd0, scan[15:8]} << 1) |
               ({4'd0, scan[23:16]} << 2) | ({4'd0, scan[31:24]} << 3);
      idx = KEY_NONE;
      if ($onehot(merged[7:0]))
         for (int i = 0; i < 8; i++)
            if (merged[i]) idx = KEY_W'(i);
      return idx;
   endfunction

   function automatic void build_frames(request_type r);
      int n0;
      longint limit;
      longint v;
      logic [3:0] dig [NDIG];
      n0 = frame_q.size();
      case (r.func)
         FUNC_SHOW: begin
            limit = 1;
            for (int i = 0; i < NDIG; i++) limit = limit * 10;
            limit = limit - 1;
            v = (r.number > limit) ? limit : r.number;
            for (int i = 0; i < NDIG; i++) begin
               dig[i] = 4'(v % 10);
               v = v / 10;
            end
            push_byte(CMD_ADDR | {4'd0, r.address}, 1, 0, KEY_NONE);
            for (int i = NDIG - 1; i >= 0; i--) begin
               push_byte(SEG_FONT[dig[i]], 1, 0, KEY_NONE);
               push_byte(SEG_FONT[dig[i]], 1, i == 0, KEY_NONE);
            end
         end
         FUNC_LED: begin
            for (int i = 0; i < NDIG; i++) begin
               push_byte(CMD_DATA_AUTO, 1, 1, KEY_NONE);
               push_byte(CMD_ADDR | BYTE_W'(2 * i + 1), 1, 0, KEY_NONE);
               push_byte({7'd0, r.data_byte[i]}, 1, 1, KEY_NONE);
            end
         end
         FUNC_INIT: begin
            push_byte(CMD_DISPLAY_ON | {5'd0, bright_model}, 1, 1, KEY_NONE);
            push_byte(CMD_DATA_AUTO, 1, 1, KEY_NONE);
            push_byte(CMD_ADDR, 1, 0, KEY_NONE);
            for (int i = 0; i < 16; i++) push_byte(FILL_BYTE, 1, i == 15, KEY_NONE);
         end
         FUNC_KEY: begin
            push_byte(CMD_READ_KEYS, 1, 0, KEY_NONE);
            push_byte('0, 0, 1, pressed_key(r.key_scan));
         end
         FUNC_WRITE: begin
            push_byte(CMD_DATA_AUTO, 1, 1, KEY_NONE);
            push_byte(CMD_ADDR | {4'd0, r.address}, 1, 0, KEY_NONE);
            push_byte(r.data_byte, 1, 1, KEY_NONE);
         end
         FUNC_FIXED: begin
            push_byte(CMD_DATA_FIXED, 1, 1, KEY_NONE);
            push_byte(CMD_ADDR | {4'd0, r.address[2:0], 1'b0}, 1, 0, KEY_NONE);
            push_byte(r.data_byte, 1, 1, KEY_NONE);
         end
         default: ;
      endcase
      if (frame_q.size() > n0) frame_q[$].last = 1'b1;
   endfunction

   // driver: present the next transaction once the current one is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            build_frames(drv_req);
            func_seen[drv_req.func]++;
         end
         if (!start || !busy) begin
            if (req_pending.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 28)) begin
               drv_req = req_pending.pop_front();
               start         <= 1'b1;
               req_func      <= drv_req.func;
               req_address   <= drv_req.address;
               req_number    <= drv_req.number;
               req_data_byte <= drv_req.data_byte;
               req_key_scan  <= drv_req.key_scan;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_byte_type exp_b;
      if (!reset && rsp_valid) begin
         if (frame_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result byte=%h valid=%b strobe=%b key=%0d last=%b",
                     $time, rsp_out_byte, rsp_byte_valid, rsp_strobe_end, rsp_key_index,
                     rsp_last);
         end else begin
            exp_b = frame_q.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== exp_b.out_byte || rsp_byte_valid !== exp_b.byte_valid ||
                rsp_strobe_end !== exp_b.strobe_end || rsp_key_index !== exp_b.key_index ||
                rsp_last !== exp_b.last) begin
               mismatches++;
               $display("%0t: expected byte=%h valid=%b strobe=%b key=%0d last=%b,",
                        $time, exp_b.out_byte, exp_b.byte_valid, exp_b.strobe_end,
                        exp_b.key_index, exp_b.last,
                        " got byte=%h valid=%b strobe=%b key=%0d last=%b",
                        rsp_out_byte, rsp_byte_valid, rsp_strobe_end, rsp_key_index,
                        rsp_last);
            end
         end
      end
   end

   function automatic request_type make_req(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                            logic [NUMBER_W-1:0] n, logic [BYTE_W-1:0] d,
                                            logic [SCAN_W-1:0] s);
      request_type r;
      r.func = f; r.address = a; r.number = n; r.data_byte = d; r.key_scan = s;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      int k;
      int b;
      r = make_req('0, ADDR_W'($urandom_range(0, 15)), NUMBER_W'($urandom),
                   BYTE_W'($urandom_range(0, 255)), $urandom);
      pick = $urandom_range(0, 99);
      if      (pick < 18) r.func = FUNC_SHOW;
      else if (pick < 32) r.func = FUNC_LED;
      else if (pick < 40) r.func = FUNC_INIT;
      else if (pick < 62) r.func = FUNC_KEY;
      else if (pick < 78) r.func = FUNC_WRITE;
      else if (pick < 94) r.func = FUNC_FIXED;
      else                r.func = $urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7;
      case ($urandom_range(0, 3))
         0: r.number = NUMBER_W'($urandom_range(0, 99999999));
         1: r.number = NUMBER_W'($urandom_range(0, 9999));
         2: r.number = NUMBER_W'($urandom_range(99999990, 100000010));
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0, 1: begin
            k = $urandom_range(0, 7);
            b = $urandom_range(0, (k < 3) ? k : 3);
            r.key_scan = '0;
            r.key_scan[8 * b + k - b] = 1'b1;
            if ($urandom_range(0, 1)) r.key_scan[k] = 1'b1;
         end
         2: r.key_scan = $urandom & $urandom & $urandom;
         default: ;
      endcase
      return r;
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (req_pending.size() != 0 || start || frame_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_brightness(logic [BRIGHT_W-1:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bright_model = v;
   endtask

   task automatic random_phase(logic [BRIGHT_W-1:0] bright, bit gaps);
      set_brightness(bright);
      gaps_on = gaps;
      req_pending.push_back(make_req(FUNC_INIT, '0, '0, '0, '0));
      for (int i = 1; i < PHASE_ITEMS; i++) req_pending.push_back(random_request());
      wait_drained();
   endtask

   initial begin
      logic [BRIGHT_W-1:0] last_bright;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      req_pending.push_back(make_req(FUNC_INIT,   4'd0,  '0,             8'h00, '0));
      req_pending.push_back(make_req(FUNC_SHOW,   4'd0,  27'd0,          8'h00, '0));
      req_pending.push_back(make_req(FUNC_SHOW,   4'd15, 27'd99999999,   8'hFF, '1));
      req_pending.push_back(make_req(FUNC_SHOW,   4'd5,  27'd100000000,  8'h00, '0));
      req_pending.push_back(make_req(FUNC_SHOW,   4'd9,  27'h7FFFFFF,    8'h00, '0));
      req_pending.push_back(make_req(FUNC_SHOW,   4'd3,  27'd12345678,   8'h00, '0));
      req_pending.push_back(make_req(FUNC_LED,    4'd0,  '0,             8'h00, '0));
      req_pending.push_back(make_req(FUNC_LED,    4'd15, '1,             8'hFF, '1));
      req_pending.push_back(make_req(FUNC_LED,    4'd2,  '0,             8'hA5, '0));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h0000_0000));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h0000_0001));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h0000_4000));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h0010_0000));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h1000_0000));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h0000_0204));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h0000_0003));
      req_pending.push_back(make_req(FUNC_KEY,    4'd0,  '0,             8'h00, 32'h8000_0000));
      req_pending.push_back(make_req(FUNC_KEY,    4'd15, '1,             8'hFF, 32'hFFFF_FFFF));
      req_pending.push_back(make_req(FUNC_WRITE,  4'd0,  '0,             8'h00, '0));
      req_pending.push_back(make_req(FUNC_WRITE,  4'd15, '1,             8'hFF, '1));
      req_pending.push_back(make_req(FUNC_FIXED,  4'd15, '0,             8'h5A, '0));
      req_pending.push_back(make_req(FUNC_FIXED,  4'd8,  '0,             8'hC3, '0));
      req_pending.push_back(make_req(FUNC_SPARE6, 4'd15, '1,             8'hFF, '1));
      req_pending.push_back(make_req(FUNC_SPARE7, 4'd0,  '0,             8'h00, '0));
      req_pending.push_back(make_req(FUNC_WRITE,  4'd7,  '0,             8'h81, '0));
      wait_drained();
      random_phase(3'd0, 1'b1);
      random_phase(3'd7, 1'b0);
      random_phase(3'd3, 1'b1);
      last_bright = BRIGHT_W'($urandom_range(1, 6));
      random_phase(last_bright, 1'b1);
      $display("covered %0d show, %0d led, %0d init, %0d key, %0d write, %0d fixed,",
               func_seen[FUNC_SHOW], func_seen[FUNC_LED], func_seen[FUNC_INIT],
               func_seen[FUNC_KEY], func_seen[FUNC_WRITE], func_seen[FUNC_FIXED],
               " %0d unused requests", func_seen[FUNC_SPARE6] + func_seen[FUNC_SPARE7]);
      $display("%0d result bytes checked at brightness 7, 0, 3 and %0d; %0d mismatches",
               bytes_checked, last_bright, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d result bytes still pending", frame_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
sv/lkdfb_pkg.sv
sv/lkdfb_front.sv
sv/lkdfb_queue.sv
sv/lkdfb_back.sv
sv/led_key_display_frame_builder_core.sv
sv/lkdfb_checker.sv
verif/tb.sv
